/* rtl/four_color_backtrack_solver_core_assert.svh */
// Assertion macros for the four-color solver RTL.
// Included by modules that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef FOUR_COLOR_BACKTRACK_SOLVER_CORE_ASSERT_SVH
`define FOUR_COLOR_BACKTRACK_SOLVER_CORE_ASSERT_SVH

// same-cycle implication
`define FCBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fcbs_pkg.sv */
// Shared types and constants of the four-color solver.
// No dependencies; imported by the interfaces and all modules.
package fcbs_pkg;

  localparam int ROW_IDX_W = 4;
  localparam int ROW_W     = 16;
  localparam int COLOR_W   = 2;
  localparam int COLORS_W  = 32;
  localparam int CNT_CFG_W = 5;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_SOLVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_POP,
    ST_POP_CHECK,
    ST_DONE_OK,
    ST_DONE_FAIL
  } fcbs_state_e;

  typedef struct packed {
    logic load_row;
    logic solve_init;
    logic scan_next;
    logic bump;
    logic commit;
    logic pop_rd;
    logic pop_dec;
    logic resume;
    logic deliver;
    logic deliver_ok;
  } fcbs_cmd_t;

  typedef struct packed {
    logic solved;
    logic scan_end;
    logic conflict;
    logic color_last;
    logic depth_zero;
    logic top_last;
    logic out_busy;
  } fcbs_sts_t;

endpackage

/* rtl/fcbs_if.sv */
// Request and response channel interfaces of the four-color solver.
// Depends on fcbs_pkg for field widths.
interface fcbs_req_if import fcbs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [ROW_IDX_W-1:0] row_index;
  logic [ROW_W-1:0]     neighbor_bits;

  modport source (output valid, kind, row_index, neighbor_bits, input ready);
  modport sink   (input valid, kind, row_index, neighbor_bits, output ready);
endinterface

interface fcbs_rsp_if import fcbs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                possible;
  logic [COLORS_W-1:0] colors;

  modport source (output valid, possible, colors, input ready);
  modport sink   (input valid, possible, colors, output ready);
endinterface

/* rtl/four_color_backtrack_solver_core.sv */
// Channel    | Dir | Payload                               | Request accepted when
// req_i      | in  | kind, row_index, neighbor_bits        | valid && ready
// rsp_o      | out | possible, colors                      | valid && ready
// node_count | cfg | node_count_i (5 bits)                 | node_count_we_i
//
// A load writes one adjacency row. A solve checks earlier nodes in turn against each
// color it tries (one registered read of the adjacency and color memories each),
// examines nodes in pop and pop-check steps while backtracking and ends in a done
// state; the total depends on the search.
// Reset clears node_count, the stack depth and the result valid; memory is unset.
// req_i is ready only between solves; one finished result waits in the output
// register while the next request is taken, and a solve result waits for that slot.
// Top level of the four-color solver; depends on fcbs_pkg, fcbs_if, fcbs_ctrl, fcbs_dpath.
module four_color_backtrack_solver_core import fcbs_pkg::*; #(
  parameter int MAX_NODES  = 16,
  parameter int NUM_COLORS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 node_count_we_i,
  input  logic [CNT_CFG_W-1:0] node_count_i,
  fcbs_req_if.sink             req_i,
  fcbs_rsp_if.source           rsp_o
);

  fcbs_cmd_t cmd;
  fcbs_sts_t sts;
  logic      req_ready;
  logic      solve_fire;

  assign req_i.ready = req_ready;
  assign solve_fire  = req_i.valid && req_ready && req_i.kind == KIND_SOLVE;

  fcbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_kind_i  (req_i.kind),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fcbs_dpath #(
    .MAX_NODES  (MAX_NODES),
    .NUM_COLORS (NUM_COLORS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .node_count_we_i (node_count_we_i),
    .node_count_i    (node_count_i),
    .row_index_i     (req_i.row_index),
    .neighbor_bits_i (req_i.neighbor_bits),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (rsp_o.valid),
    .out_ready_i     (rsp_o.ready),
    .possible_o      (rsp_o.possible),
    .colors_o        (rsp_o.colors)
  );

`include "four_color_backtrack_solver_core_assert.svh"

  `FCBS_ASSERT_NOW(a_fail_zero, rsp_o.valid && !rsp_o.possible, rsp_o.colors == '0, "fail with colors")
  `FCBS_ASSERT_NOW(a_deliver_free, cmd.deliver, !(rsp_o.valid && !rsp_o.ready), "result overwritten")
  `FCBS_ASSERT_NEXT(a_solve_busy, solve_fire, !req_ready, "request taken during a solve")

endmodule

/* rtl/fcbs_ctrl.sv */
// Controller FSM of the four-color solver: sequences scan, commit and backtrack.
// Depends on fcbs_pkg; drives fcbs_dpath through fcbs_cmd_t.
module fcbs_ctrl import fcbs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  input  logic      req_kind_i,
  output logic      req_ready_o,
  input  fcbs_sts_t sts_i,
  output fcbs_cmd_t cmd_o
);

  fcbs_state_e state_q, state_d;
  logic        req_fire;

  assign req_fire = req_valid_i && req_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire && req_kind_i == KIND_SOLVE) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.solved) state_d = ST_DONE_OK;
        else if (!sts_i.scan_end) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.conflict) state_d = sts_i.color_last ? ST_POP : ST_SCAN;
        else state_d = ST_SCAN;
      end
      ST_POP: begin
        state_d = sts_i.depth_zero ? ST_DONE_FAIL : ST_POP_CHECK;
      end
      ST_POP_CHECK: begin
        state_d = sts_i.top_last ? ST_POP : ST_SCAN;
      end
      ST_DONE_OK, ST_DONE_FAIL: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o      = 1'b1;
        cmd_o.load_row   = req_fire && req_kind_i == KIND_LOAD;
        cmd_o.solve_init = req_fire && req_kind_i == KIND_SOLVE;
      end
      ST_SCAN: begin
        cmd_o.commit = !sts_i.solved && sts_i.scan_end;
      end
      ST_CHECK: begin
        cmd_o.bump      = sts_i.conflict && !sts_i.color_last;
        cmd_o.scan_next = !sts_i.conflict;
      end
      ST_POP: begin
        cmd_o.pop_rd = !sts_i.depth_zero;
      end
      ST_POP_CHECK: begin
        cmd_o.pop_dec = sts_i.top_last;
        cmd_o.resume  = !sts_i.top_last;
      end
      ST_DONE_OK: begin
        cmd_o.deliver    = !sts_i.out_busy;
        cmd_o.deliver_ok = 1'b1;
      end
      ST_DONE_FAIL: begin
        cmd_o.deliver = !sts_i.out_busy;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/fcbs_dpath.sv */
// Datapath of the four-color solver: adjacency and color memories, depth and
// scan counters, packed colors and the result register. Depends on fcbs_pkg.
module fcbs_dpath import fcbs_pkg::*; #(
  parameter int MAX_NODES  = 16,
  parameter int NUM_COLORS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 node_count_we_i,
  input  logic [CNT_CFG_W-1:0] node_count_i,
  input  logic [ROW_IDX_W-1:0] row_index_i,
  input  logic [ROW_W-1:0]     neighbor_bits_i,
  input  fcbs_cmd_t            cmd_i,
  output fcbs_sts_t            sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 possible_o,
  output logic [COLORS_W-1:0]  colors_o
);

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NW = $clog2(MAX_NODES + 1);
  localparam logic [COLOR_W-1:0] LastColor = COLOR_W'(NUM_COLORS - 1);
  localparam int PackNodes = COLORS_W / COLOR_W;

  logic [ROW_W-1:0]    adj_mem [MAX_NODES];
  logic [COLOR_W-1:0]  col_mem [MAX_NODES];
  logic [ROW_W-1:0]    adj_rd_q;
  logic [COLOR_W-1:0]  col_rd_q;

  logic [NW-1:0]       n_q, d_q, d_d, idx_q, idx_d;
  logic [COLOR_W-1:0]  c_q, c_d;
  logic [COLORS_W-1:0] colors_q;
  logic                out_valid_q, out_possible_q;
  logic [COLORS_W-1:0] out_colors_q;

  logic [31:0]         d_ext, row_ext;
  logic [NW-1:0]       d_m1;
  logic [IW-1:0]       rd_addr;
  logic                adj_bit;
  logic [4:0]          pack_pos;

  assign d_ext    = 32'(d_q);
  assign row_ext  = 32'(row_index_i);
  assign d_m1     = d_q - NW'(1);
  assign rd_addr  = cmd_i.pop_rd ? d_m1[IW-1:0] : idx_q[IW-1:0];
  assign adj_bit  = (d_ext < 32'(ROW_W)) ? adj_rd_q[d_ext[ROW_IDX_W-1:0]] : 1'b0;
  assign pack_pos = {d_ext[3:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row && row_ext < 32'(MAX_NODES)) begin
      adj_mem[row_ext[IW-1:0]] <= neighbor_bits_i;
    end
    adj_rd_q <= adj_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      col_mem[d_q[IW-1:0]] <= c_q;
    end
    col_rd_q <= col_mem[rd_addr];
  end

  always_comb begin
    d_d   = d_q;
    idx_d = idx_q;
    c_d   = c_q;
    if (cmd_i.solve_init) begin
      d_d   = '0;
      idx_d = '0;
      c_d   = '0;
    end else if (cmd_i.scan_next) begin
      idx_d = idx_q + NW'(1);
    end else if (cmd_i.bump) begin
      idx_d = '0;
      c_d   = c_q + COLOR_W'(1);
    end else if (cmd_i.commit) begin
      d_d   = d_q + NW'(1);
      idx_d = '0;
      c_d   = '0;
    end else if (cmd_i.pop_dec) begin
      d_d = d_m1;
    end else if (cmd_i.resume) begin
      d_d   = d_m1;
      idx_d = '0;
      c_d   = col_rd_q + COLOR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      d_q         <= '0;
      idx_q       <= '0;
      c_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (node_count_we_i) begin
        if (32'(node_count_i) > 32'(MAX_NODES)) n_q <= NW'(MAX_NODES);
        else n_q <= NW'(node_count_i);
      end
      d_q   <= d_d;
      idx_q <= idx_d;
      c_q   <= c_d;
      if (cmd_i.deliver) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.solve_init) begin
      colors_q <= '0;
    end else if (cmd_i.commit && d_ext < 32'(PackNodes)) begin
      colors_q[pack_pos +: COLOR_W] <= c_q;
    end
    if (cmd_i.deliver) begin
      out_possible_q <= cmd_i.deliver_ok;
      out_colors_q   <= cmd_i.deliver_ok ? colors_q : '0;
    end
  end

  assign sts_o.solved     = d_q == n_q;
  assign sts_o.scan_end   = idx_q == d_q;
  assign sts_o.conflict   = adj_bit && col_rd_q == c_q;
  assign sts_o.color_last = c_q == LastColor;
  assign sts_o.depth_zero = d_q == '0;
  assign sts_o.top_last   = col_rd_q == LastColor;
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign possible_o  = out_possible_q;
  assign colors_o    = out_colors_q;

endmodule
